FILE: sv/pctt_pkg.sv
`default_nettype none

package pctt_pkg;

  // Table geometry and value width.
  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;

  // Fixed widths of the ports.
  localparam int IO_W  = 32;
  localparam int TOL_W = 31;
  localparam int NUM_LANES = 4;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  // Signed width wide enough for a difference of two values and the tolerance.
  localparam int CMP_W  = ((VALUE_WIDTH + 1 > TOL_W + 1) ? VALUE_WIDTH + 1 : TOL_W + 1) + 1;

  // Operation codes carried by func.
  localparam logic [1:0] FUNC_FIND  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic start;
    logic add;
    logic clear;
    logic ack;
  } lane_cmd_t;

  typedef struct packed {
    logic                   done;
    logic                   hit;
    logic                   ovf;
    logic [VALUE_WIDTH-1:0] data;
  } lane_res_t;

  // Reduce a port value to the table width, sign extended.
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic signed [IO_W-1:0] x);
    logic signed [63:0] wide;
    wide = 64'(x);
    return wide[VALUE_WIDTH-1:0];
  endfunction

  // Widen or cut a table value back to the port width.
  function automatic logic [IO_W-1:0] to_port(input logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] wide;
    wide = 64'(signed'(v));
    return wide[IO_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pctt_lane.sv
`default_nettype none

module pctt_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pctt_pkg::TOL_W-1:0]       tolerance,
  input  logic [pctt_pkg::VALUE_WIDTH-1:0] value,
  input  pctt_pkg::lane_cmd_t              cmd,
  output pctt_pkg::lane_res_t              res
);
  import pctt_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_SCAN = 3'b010,
    L_DONE = 3'b100
  } lane_state_t;

  lane_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] hit_data;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       ptr;
  logic                   rd_vld;
  logic                   hit;
  logic                   ovf;
  logic                   issue;
  logic                   match;
  logic                   miss;
  logic                   full;
  logic                   append;
  logic signed [VALUE_WIDTH:0] diff;
  logic signed [CMP_W-1:0]     diff_ext;
  logic signed [CMP_W-1:0]     tol_pos;
  logic signed [CMP_W-1:0]     tol_neg;

  // One read per cycle walks the entries in insertion order.
  assign issue = (state == L_SCAN) && (ptr < count);

  // The difference is one bit wider than the values, so it never wraps.
  assign diff     = signed'({rd_data[VALUE_WIDTH-1], rd_data})
                  - signed'({value[VALUE_WIDTH-1], value});
  assign diff_ext = CMP_W'(diff);
  assign tol_pos  = signed'(CMP_W'(tolerance));
  assign tol_neg  = -tol_pos;

  assign match  = (state == L_SCAN) && rd_vld && (diff_ext < tol_pos) && (diff_ext > tol_neg);
  assign miss   = (state == L_SCAN) && !rd_vld && !issue;
  assign full   = (count == CNT_W'(TABLE_DEPTH));
  assign append = miss && cmd.add && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: begin
        if (cmd.start) state_next = L_SCAN;
      end
      L_SCAN: begin
        if (match || miss) state_next = L_DONE;
      end
      L_DONE: begin
        if (cmd.ack) state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue && !match;
      if (cmd.clear) begin
        count <= '0;
      end else if (append) begin
        count <= count + 1'b1;
      end
      if (cmd.start) begin
        hit <= 1'b0;
        ovf <= 1'b0;
      end else if (match) begin
        hit <= 1'b1;
      end else if (miss) begin
        ovf <= cmd.add && full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr <= '0;
    end else if (issue) begin
      ptr <= ptr + 1'b1;
    end
    if (match) hit_data <= rd_data;
  end

  // Table memory: one read port for the scan, one write port for appends.
  always_ff @(posedge clk) begin
    if (issue) rd_data <= mem[ptr[ADDR_W-1:0]];
    if (append) mem[count[ADDR_W-1:0]] <= value;
  end

  assign res.done = (state == L_DONE);
  assign res.hit  = hit;
  assign res.ovf  = ovf;
  assign res.data = hit_data;

endmodule

`default_nettype wire

FILE: sv/plane_component_tolerance_table_core.sv
// Plane component tolerance table.
// A request on the input channel (in_valid/in_ready) carries func and a plane
// as four signed Q16.16 components. Find looks every component up in its own
// table; add also appends each component that found no match; clear empties
// all four tables. Each request gives exactly one result on the output channel
// (out_valid/out_ready): found, the four snapped components and overflow.
// The four tables are searched by four lanes side by side, each scanning its
// own memory one entry per cycle through a single read port, and a merging
// stage then forms the result. A find or add lasts until every lane has
// finished its scan; a scan runs longer the fuller its table is and ends
// early when the lane hits. Clear and the unused code need no scan. A new
// request is taken only once the result of the last one has been loaded
// into the output register, which happens when that register is free.
// The tolerance register is written through cfg_we/cfg_wdata; the user must
// do so only while the block is idle, which the block itself does not
// enforce. Reset empties all tables, sets the tolerance to 7 and drops
// out_valid. A result waits in the output register while the receiver stalls;
// a new request is still taken meanwhile, but its result is held in the
// merging stage until the output register is free.
`default_nettype none

module plane_component_tolerance_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pctt_pkg::TOL_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic signed [pctt_pkg::IO_W-1:0] normal_x,
  input  logic signed [pctt_pkg::IO_W-1:0] normal_y,
  input  logic signed [pctt_pkg::IO_W-1:0] normal_z,
  input  logic signed [pctt_pkg::IO_W-1:0] plane_distance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [pctt_pkg::IO_W-1:0] snapped_x,
  output logic signed [pctt_pkg::IO_W-1:0] snapped_y,
  output logic signed [pctt_pkg::IO_W-1:0] snapped_z,
  output logic signed [pctt_pkg::IO_W-1:0] snapped_distance,
  output logic                          overflow
);
  import pctt_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_BUSY = 2'b10
  } top_state_t;

  top_state_t state, state_next;

  logic [TOL_W-1:0]       tolerance;
  logic [1:0]             func_q;
  logic [VALUE_WIDTH-1:0] val_q   [NUM_LANES];
  logic [IO_W-1:0]        in_word [NUM_LANES];
  logic [IO_W-1:0]        snap_next [NUM_LANES];
  lane_cmd_t              lane_cmd [NUM_LANES];
  lane_res_t              lane_res [NUM_LANES];
  logic [NUM_LANES-1:0]   lane_done;
  logic [NUM_LANES-1:0]   lane_hit;
  logic [NUM_LANES-1:0]   lane_ovf;
  logic                   accept;
  logic                   lookup_in;
  logic                   lookup_q;
  logic                   add_q;
  logic                   all_hit;
  logic                   out_free;
  logic                   load;

  assign in_word[0] = normal_x;
  assign in_word[1] = normal_y;
  assign in_word[2] = normal_z;
  assign in_word[3] = plane_distance;

  // One request is in work at a time; the output register parts the sides.
  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign lookup_in = (func == FUNC_FIND) || (func == FUNC_ADD);
  assign lookup_q  = (func_q == FUNC_FIND) || (func_q == FUNC_ADD);
  assign add_q     = (func_q == FUNC_ADD);
  assign out_free  = !out_valid || out_ready;

  // Clear and the unused code need no lane work; lookups wait for all lanes.
  assign load = (state == T_BUSY) && out_free && (!lookup_q || (&lane_done));

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (accept) state_next = T_BUSY;
      end
      T_BUSY: begin
        if (load) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      tolerance <= TOL_W'(7);
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) tolerance <= cfg_wdata;
    end
  end

  // The lanes read the held components for the whole of a lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      for (int c = 0; c < NUM_LANES; c++) begin
        val_q[c] <= to_value(in_word[c]);
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_cmd[g].start = accept && lookup_in;
    assign lane_cmd[g].add   = add_q;
    assign lane_cmd[g].clear = accept && (func == FUNC_CLEAR);
    assign lane_cmd[g].ack   = load && lookup_q;

    pctt_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .tolerance (tolerance),
      .value     (val_q[g]),
      .cmd       (lane_cmd[g]),
      .res       (lane_res[g])
    );

    assign lane_done[g] = lane_res[g].done;
    assign lane_hit[g]  = lane_res[g].hit;
    assign lane_ovf[g]  = lane_res[g].ovf;
  end

  // Merging stage. A find only snaps when every component hit; an add snaps
  // each component that hit and passes the others through.
  assign all_hit = &lane_hit;

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      if (!lookup_q) begin
        snap_next[c] = '0;
      end else if (lane_hit[c] && (add_q || all_hit)) begin
        snap_next[c] = to_port(lane_res[c].data);
      end else begin
        snap_next[c] = to_port(val_q[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found            <= lookup_q && all_hit;
      overflow         <= add_q && (|lane_ovf);
      snapped_x        <= snap_next[0];
      snapped_y        <= snap_next[1];
      snapped_z        <= snap_next[2];
      snapped_distance <= snap_next[3];
    end
  end

endmodule

`default_nettype wire

FILE: dv/plane_component_tolerance_table_core_tb.sv
`default_nettype none

// Testbench for the plane component tolerance table.
//
// A queue of pending requests is filled by the sequencing block below. A driver
// clocked on the falling edge presents them on the input channel. A monitor on
// the rising edge does two things. It runs every accepted request through a
// predictor that keeps its own copy of the four component tables and the
// tolerance. It also checks every result against the oldest outstanding
// prediction. The tolerance is only rewritten once the block has gone quiet.
module plane_component_tolerance_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pctt_pkg::*;

  // The package names three codes. The fourth one is legal on the port and
  // must leave the tables alone and give an all-zero result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam longint RESET_TOLERANCE = 7;
  localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};
  localparam int NUM_COMP = 4;
  localparam int POOL_SIZE = 24;
  localparam int RECENT_DEPTH = 16;
  // The slowest request scans a full table. On top of that come the long
  // receiver hold-off and the random gaps. The limit sits several times above
  // all of these put together.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 400;

  typedef struct {
    logic [1:0]             func;
    logic signed [IO_W-1:0] comp [NUM_COMP];
  } plane_req_t;

  typedef struct {
    logic            found;
    logic [IO_W-1:0] snap [NUM_COMP];
    logic            overflow;
  } plane_result_t;

  // Clock, reset and the ports of the block.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_FIND;
  logic signed [IO_W-1:0] normal_x = '0;
  logic signed [IO_W-1:0] normal_y = '0;
  logic signed [IO_W-1:0] normal_z = '0;
  logic signed [IO_W-1:0] plane_distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic signed [IO_W-1:0] snapped_x;
  logic signed [IO_W-1:0] snapped_y;
  logic signed [IO_W-1:0] snapped_z;
  logic signed [IO_W-1:0] snapped_distance;
  logic overflow;

  always #10 clk = ~clk;

  plane_component_tolerance_table_core DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .normal_x         (normal_x),
    .normal_y         (normal_y),
    .normal_z         (normal_z),
    .plane_distance   (plane_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .snapped_x        (snapped_x),
    .snapped_y        (snapped_y),
    .snapped_z        (snapped_z),
    .snapped_distance (snapped_distance),
    .overflow         (overflow)
  );

  // The predictor's view of the block: four tables of sign-extended values,
  // their fill counts and the tolerance that is currently programmed.
  longint comp_table [NUM_COMP][TABLE_DEPTH];
  int     comp_count [NUM_COMP] = '{default: 0};
  longint tol_now = RESET_TOLERANCE;

  plane_req_t    plane_pending_q [$];
  plane_result_t plane_expect_q [$];
  plane_req_t    recent_adds_q [$];
  logic [IO_W-1:0] value_pool [POOL_SIZE];
  logic [IO_W-1:0] extreme_vals [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                        32'h1};
  string comp_name [NUM_COMP] = '{"snapped_x", "snapped_y", "snapped_z", "snapped_distance"};

  int  issued_count = 0;
  int  accepted_count = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  tolerance_writes = 0;
  int  find_count = 0, add_count = 0, clear_count = 0, unused_count = 0;
  int  found_count = 0, overflow_count = 0;
  bit  calm = 1'b0;
  logic in_taken = 1'b0;
  plane_req_t next_req;

  // Works out the result of one request and updates the tables as the block
  // should. Each component is looked up on its own. The first entry in order
  // of insertion that lies strictly closer than the tolerance is taken. The
  // difference is formed wide enough that values at opposite ends of the range
  // never appear close by wrapping round.
  function automatic plane_result_t snap_plane(input plane_req_t r);
    plane_result_t res;
    longint val [NUM_COMP];
    longint outv [NUM_COMP];
    int hit [NUM_COMP];
    bit all_hit;
    bit ovf;
    longint wide;
    logic signed [65:0] wa, wb, gap_abs;
    res.found = 1'b0;
    res.overflow = 1'b0;
    all_hit = 1'b1;
    ovf = 1'b0;
    for (int c = 0; c < NUM_COMP; c++) outv[c] = 0;
    if (r.func == FUNC_CLEAR) begin
      for (int c = 0; c < NUM_COMP; c++) comp_count[c] = 0;
    end else if (r.func == FUNC_FIND || r.func == FUNC_ADD) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        wide = longint'(r.comp[c]);
        val[c] = (wide <<< (64 - VALUE_WIDTH)) >>> (64 - VALUE_WIDTH);
        hit[c] = -1;
        for (int i = 0; i < comp_count[c]; i++) begin
          if (hit[c] < 0) begin
            wa = comp_table[c][i];
            wb = val[c];
            gap_abs = wa - wb;
            if (gap_abs < 0) gap_abs = -gap_abs;
            if (gap_abs < tol_now) hit[c] = i;
          end
        end
        if (hit[c] < 0) all_hit = 1'b0;
      end
      // Found is judged on the tables as they stood before any append.
      for (int c = 0; c < NUM_COMP; c++) begin
        if (hit[c] >= 0 && (r.func == FUNC_ADD || all_hit)) begin
          outv[c] = comp_table[c][hit[c]];
        end else begin
          // A find miss passes every component through, even those that hit.
          outv[c] = val[c];
          if (r.func == FUNC_ADD && hit[c] < 0) begin
            if (comp_count[c] < TABLE_DEPTH) begin
              comp_table[c][comp_count[c]] = val[c];
              comp_count[c]++;
            end else begin
              ovf = 1'b1;
            end
          end
        end
      end
      res.found = all_hit;
      res.overflow = ovf;
    end
    for (int c = 0; c < NUM_COMP; c++) res.snap[c] = IO_W'(outv[c]);
    return res;
  endfunction

  // One random component. Most values sit near a small pool of bases, so
  // that matches are common. Some sit right on either side of the tolerance
  // boundary. The rest are fully random words or extremes of the range.
  function automatic logic [IO_W-1:0] pick_component();
    int sel;
    logic [IO_W-1:0] base;
    sel = $urandom_range(99);
    base = value_pool[$urandom_range(POOL_SIZE - 1)];
    if (sel < 50) return base + IO_W'(int'($urandom_range(20)) - 10);
    if (sel < 65) begin
      case ($urandom_range(3))
        0: return base + IO_W'(tol_now);
        1: return base - IO_W'(tol_now);
        2: return base + IO_W'(tol_now - 1);
        default: return base - IO_W'(tol_now - 1);
      endcase
    end
    if (sel < 90) return $urandom();
    return extreme_vals[$urandom_range(4)];
  endfunction

  // Builds one random request. A share of the finds go back to a plane that
  // was added a little earlier, sometimes nudged by a few units. That way the
  // full-match path is exercised and does not depend on luck alone.
  function automatic plane_req_t make_request(input int add_pct, input int clear_pm);
    plane_req_t r;
    plane_req_t prior;
    int roll;
    roll = $urandom_range(999);
    if (roll < clear_pm) r.func = FUNC_CLEAR;
    else if (roll < clear_pm + 15) r.func = FUNC_UNUSED;
    else if ($urandom_range(99) < add_pct) r.func = FUNC_ADD;
    else r.func = FUNC_FIND;
    for (int c = 0; c < NUM_COMP; c++) r.comp[c] = pick_component();
    if (r.func == FUNC_FIND && recent_adds_q.size() > 0 && $urandom_range(99) < 40) begin
      prior = recent_adds_q[$urandom_range(recent_adds_q.size() - 1)];
      for (int c = 0; c < NUM_COMP; c++) begin
        r.comp[c] = prior.comp[c];
        if ($urandom_range(3) == 0) r.comp[c] = prior.comp[c] + IO_W'(int'($urandom_range(6)) - 3);
      end
    end
    if (r.func == FUNC_ADD) begin
      recent_adds_q.insert(recent_adds_q.size(), r);
      if (recent_adds_q.size() > RECENT_DEPTH) void'(recent_adds_q.pop_front());
    end
    return r;
  endfunction

  task automatic push_plane(input logic [1:0] f, input logic [IO_W-1:0] x, input logic [IO_W-1:0] y,
                            input logic [IO_W-1:0] z, input logic [IO_W-1:0] d);
    plane_req_t r;
    r.func = f;
    r.comp[0] = x;
    r.comp[1] = y;
    r.comp[2] = z;
    r.comp[3] = d;
    plane_pending_q.insert(plane_pending_q.size(), r);
    issued_count++;
  endtask

  // Waits until every request has been taken and answered. Then it waits out
  // a table scan's worth of cycles so that the block is surely quiet.
  task automatic settle();
    while (accepted_count < issued_count || plane_expect_q.size() > 0) @(negedge clk);
    repeat (TABLE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tol_now = value;
    tolerance_writes++;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [TOL_W-1:0] tol, input int n, input int add_pct,
                                  input int clear_pm, input bit quiet);
    write_tolerance(tol);
    for (int i = 0; i < POOL_SIZE; i++) begin
      value_pool[i] = ($urandom_range(7) == 0) ? extreme_vals[$urandom_range(4)] : $urandom();
    end
    calm = quiet;
    repeat (n) begin
      plane_pending_q.insert(plane_pending_q.size(), make_request(add_pct, clear_pm));
      issued_count++;
    end
    settle();
    calm = 1'b0;
  endtask

  // The driver works on the falling edge. A request stays on the port until
  // the rising edge has seen it taken. Then either the next one goes up or the
  // channel idles.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (plane_pending_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
        next_req = plane_pending_q.pop_front();
        func <= next_req.func;
        normal_x <= next_req.comp[0];
        normal_y <= next_req.comp[1];
        normal_z <= next_req.comp[2];
        plane_distance <= next_req.comp[3];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random. Once the run is well under way it also
  // holds off for a long stretch. Meanwhile the driver keeps offering
  // requests, so the block fills its pipeline and has to stop taking input.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // The monitor checks results first and only then records the request taken
  // at the same edge. Its result cannot appear before a later edge.
  always @(posedge clk) begin : monitor
    plane_req_t    taken;
    plane_result_t want;
    logic [IO_W-1:0] got [NUM_COMP];
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (plane_expect_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = plane_expect_q.pop_front();
          got[0] = snapped_x;
          got[1] = snapped_y;
          got[2] = snapped_z;
          got[3] = snapped_distance;
          if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            mismatch_count++;
          end
          for (int c = 0; c < NUM_COMP; c++) begin
            if (got[c] !== want.snap[c]) begin
              $error("%s: expected %h, got %h", comp_name[c], want.snap[c], got[c]);
              mismatch_count++;
            end
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken.func = func;
        taken.comp[0] = normal_x;
        taken.comp[1] = normal_y;
        taken.comp[2] = normal_z;
        taken.comp[3] = plane_distance;
        want = snap_plane(taken);
        plane_expect_q.insert(plane_expect_q.size(), want);
        accepted_count++;
        case (func)
          FUNC_FIND:  find_count++;
          FUNC_ADD:   add_count++;
          FUNC_CLEAR: clear_count++;
          default:    unused_count++;
        endcase
        if (want.found) found_count++;
        if (want.overflow) overflow_count++;
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("plane_component_tolerance_table_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset tolerance of 7.
    // A find on empty tables misses and passes the plane through.
    push_plane(FUNC_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_plane(FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_plane(FUNC_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    // All components lie six units off the stored values, so they snap.
    push_plane(FUNC_FIND, 32'h8000_0006, 32'h7FFF_FFF9, 32'h6, 32'hFFFF_FFF9);
    // A difference of exactly the tolerance is a miss. On a find miss the
    // whole plane passes through.
    push_plane(FUNC_FIND, 32'h8000_0007, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    // Opposite ends of the range must not meet by wrapping.
    push_plane(FUNC_FIND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    // An add with a mix of new and matching components.
    push_plane(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3, 32'd100);
    push_plane(FUNC_ADD, 32'h8000_0001, 32'h7FFF_FFFE, 32'hFFFF_FFFD, 32'd100);
    push_plane(FUNC_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    push_plane(FUNC_FIND, 32'd1, 32'd2, 32'd3, 32'd4);
    // A clear answers with zeros whatever the plane carried.
    push_plane(FUNC_CLEAR, 32'd5, 32'd6, 32'd7, 32'd8);
    push_plane(FUNC_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_plane(FUNC_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0003_0000);
    push_plane(FUNC_ADD, 32'h0001_0005, 32'hFFFE_FFFB, 32'h0000_8003, 32'h0003_0000);

    // With a tolerance of zero nothing can ever match, so a repeat is new.
    write_tolerance('0);
    push_plane(FUNC_ADD, 32'h1234_5678, 32'hEDCB_A988, 32'h0, 32'h1);
    push_plane(FUNC_ADD, 32'h1234_5678, 32'hEDCB_A988, 32'h0, 32'h1);
    push_plane(FUNC_FIND, 32'h1234_5678, 32'hEDCB_A988, 32'h0, 32'h1);

    // The widest tolerance matches almost anything but the far end of the range.
    write_tolerance(TOL_MAX);
    push_plane(FUNC_FIND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_plane(FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_plane(FUNC_FIND, 32'hFFFF_FFFF, 32'h0, 32'h8000_0001, 32'h7FFF_FFFE);
    push_plane(FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);

    // Random phases. The first one is mostly adds at zero tolerance, so the
    // tables fill up quickly and overflow is reached. One phase runs without
    // gaps on either side.
    run_random_phase('0, 220, 85, 0, 1'b0);
    run_random_phase(31'd1, 200, 50, 10, 1'b0);
    run_random_phase(31'(RESET_TOLERANCE), 200, 50, 10, 1'b0);
    run_random_phase(31'h100, 200, 50, 10, 1'b1);
    run_random_phase(31'h0001_0000, 200, 50, 10, 1'b0);
    run_random_phase(TOL_MAX, 200, 50, 10, 1'b0);
    run_random_phase(31'($urandom_range(32'h7FFF_FFFF)), 200, 50, 10, 1'b0);

    settle();
    if (plane_expect_q.size() > 0) begin
      $error("%0d expected results never arrived", plane_expect_q.size());
      mismatch_count++;
    end
    $display("Covered %0d requests (%0d find, %0d add, %0d clear, %0d unused code) over %0d %s",
             accepted_count, find_count, add_count, clear_count, unused_count, tolerance_writes,
             "tolerance writes.");
    $display("%0d results were full matches, %0d hit a full table; %0d mismatches.",
             found_count, overflow_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("plane_component_tolerance_table_core_tb: PASS");
    end else begin
      $display("plane_component_tolerance_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
